// ----- sv/tce_pkg.sv -----
// Shared types, opcodes and sizes for the tiny CPU execute unit.
package tce_pkg;

    localparam int RAM_DEPTH_DEF = 128;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [3:0] OP_LD  = 4'h0;
    localparam logic [3:0] OP_ST  = 4'h2;
    localparam logic [3:0] OP_MOV = 4'h4;
    localparam logic [3:0] OP_LDI = 4'h5;
    localparam logic [3:0] OP_ADD = 4'h6;
    localparam logic [3:0] OP_SUB = 4'h7;
    localparam logic [3:0] OP_SHL = 4'h8;
    localparam logic [3:0] OP_SHR = 4'h9;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_OUT = 4'hC;
    localparam logic [3:0] OP_IN  = 4'hD;
    localparam logic [3:0] OP_BZ  = 4'hE;
    localparam logic [3:0] OP_JMP = 4'hF;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic [7:0] instr_byte;
        logic [7:0] in_char;
    } in_t;

    typedef struct packed {
        logic [7:0] next_pc;
        logic       out_valid;
        logic [7:0] out_value;
        logic       halted;
        logic       zero_out;
    } out_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] rx;
        logic [1:0] ry;
        logic [3:0] imm;
        logic       digit_ok;
        logic [3:0] digit_val;
        logic       illegal;
    } dec_t;

endpackage

// ----- sv/tce_ram.sv -----
// Generic single-port-write RAM with registered read.
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- sv/tce_queue.sv -----
// Small register queue with push/full and pop/empty sides.
module tce_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = tce_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/tce_front.sv -----
// Front end: splits an instruction request into decoded fields.
module tce_front (
    input  tce_pkg::in_t  cmd,
    output tce_pkg::dec_t dec
);

    import tce_pkg::*;

    logic [7:0] ch_off;

    assign ch_off = cmd.in_char - CHAR_ZERO;

    always_comb
    begin
        dec.op        = cmd.instr_byte[7:4];
        dec.rx        = cmd.instr_byte[3:2];
        dec.ry        = cmd.instr_byte[1:0];
        dec.imm       = cmd.instr_byte[3:0];
        dec.digit_ok  = (cmd.in_char >= CHAR_ZERO) && (cmd.in_char <= CHAR_NINE);
        dec.digit_val = ch_off[3:0];
        case (cmd.instr_byte[7:4])
            OP_LD, OP_ST, OP_MOV, OP_LDI, OP_ADD, OP_SUB, OP_SHL, OP_SHR,
            OP_CMP, OP_OUT, OP_IN, OP_BZ, OP_JMP: dec.illegal = 1'b0;
            default:                               dec.illegal = 1'b1;
        endcase
    end

endmodule

// ----- sv/tce_exec.sv -----
// Back end: register file, flags, data RAM and per-instruction execution.
module tce_exec #(
    parameter int RAM_DEPTH = tce_pkg::RAM_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tce_pkg::dec_t dec,
    input  logic          dec_empty,
    output logic          dec_pop,
    output tce_pkg::out_t rsp,
    output logic          rsp_push,
    input  logic          rsp_full
);

    import tce_pkg::*;

    localparam int AW = $clog2(RAM_DEPTH);

    logic [7:0]           pc_reg, pc_next;
    logic [7:0]           gp_reg [4];
    logic [7:0]           gp_next [4];
    logic                 zero_reg, zero_next;
    logic                 halt_reg, halt_next;
    logic [RAM_DEPTH-1:0] valid_reg, valid_next;
    logic                 load_wait_reg, load_wait_next;
    logic                 ld_valid_reg;

    logic [7:0]    a, b, ld_val, ram_rdata;
    logic [AW-1:0] addr;
    logic          in_range, needs_ld, ld_issue, step, ram_we;

    assign a        = gp_reg[dec.rx];
    assign b        = gp_reg[dec.ry];
    assign addr     = b[AW-1:0];
    assign in_range = ({1'b0, b} < 9'(RAM_DEPTH));
    assign needs_ld = !halt_reg && (dec.op == OP_LD) && in_range;
    assign step     = !dec_empty && !rsp_full && (!needs_ld || load_wait_reg);
    assign ld_issue = !dec_empty && !rsp_full && needs_ld && !load_wait_reg;
    assign ld_val   = ld_valid_reg ? ram_rdata : 8'h00;
    assign ram_we   = step && !halt_reg && (dec.op == OP_ST) && in_range;
    assign dec_pop  = step;
    assign rsp_push = step;

    tce_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (gp_reg[0]),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pc_next       = pc_reg + 8'd1;
        gp_next       = gp_reg;
        zero_next     = zero_reg;
        halt_next     = halt_reg;
        valid_next    = valid_reg;
        rsp.out_valid = 1'b0;
        rsp.out_value = 8'h00;
        if (halt_reg)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            case (dec.op)
                OP_LD:
                begin
                    if (in_range)
                    begin
                        gp_next[0] = ld_val;
                        zero_next  = (ld_val == 8'h00);
                    end
                end
                OP_ST:
                begin
                    if (in_range)
                    begin
                        valid_next[addr] = 1'b1;
                        zero_next        = (gp_reg[0] == 8'h00);
                    end
                end
                OP_MOV:
                begin
                    gp_next[dec.ry] = a;
                end
                OP_LDI:
                begin
                    gp_next[0] = {4'h0, dec.imm};
                    zero_next  = (dec.imm == 4'h0);
                end
                OP_ADD:
                begin
                    gp_next[0] = a + b;
                    zero_next  = ((a + b) == 8'h00);
                end
                OP_SUB:
                begin
                    gp_next[0] = a - b;
                    zero_next  = (a == b);
                end
                OP_SHL:
                begin
                    gp_next[0] = {b[6:0], 1'b0};
                    zero_next  = (b[6:0] == 7'h00);
                end
                OP_SHR:
                begin
                    gp_next[0] = {1'b0, b[7:1]};
                    zero_next  = (b[7:1] == 7'h00);
                end
                OP_CMP:
                begin
                    zero_next = (b == 8'h00);
                end
                OP_OUT:
                begin
                    rsp.out_valid = 1'b1;
                    rsp.out_value = b;
                end
                OP_IN:
                begin
                    if (dec.digit_ok)
                    begin
                        gp_next[dec.ry] = {4'h0, dec.digit_val};
                    end
                end
                OP_BZ:
                begin
                    if (zero_reg)
                    begin
                        pc_next = b;
                    end
                end
                OP_JMP:
                begin
                    pc_next = b;
                end
                default:
                begin
                    halt_next = 1'b1;
                    pc_next   = pc_reg;
                end
            endcase
        end
        rsp.next_pc  = pc_next;
        rsp.halted   = halt_next;
        rsp.zero_out = zero_next;
    end

    always_comb
    begin
        load_wait_next = load_wait_reg;
        if (ld_issue)
        begin
            load_wait_next = 1'b1;
        end
        else if (step)
        begin
            load_wait_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            gp_reg        <= '{default: '0};
            zero_reg      <= 1'b0;
            halt_reg      <= 1'b0;
            valid_reg     <= '0;
            load_wait_reg <= 1'b0;
        end
        else
        begin
            load_wait_reg <= load_wait_next;
            if (step)
            begin
                pc_reg    <= pc_next;
                gp_reg    <= gp_next;
                zero_reg  <= zero_next;
                halt_reg  <= halt_next;
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_issue)
        begin
            ld_valid_reg <= valid_reg[addr];
        end
    end

endmodule

// ----- sv/tiny_cpu_execute_unit_core.sv -----
// Top level of the tiny CPU execute unit: front decode, queues and back end.
// A request passes through the registered decode queue, the back end and the
// registered response queue; a data RAM load stalls the back end for the RAM read.
// Throughput: one instruction per cycle while the response queue is not full.
// Reset (rst_n low, asynchronous) clears pc, registers, flags, queues and the RAM's
// per-entry valid bits at once; unwritten RAM entries read as zero, no sweep.
module tiny_cpu_execute_unit_core #(
    parameter int RAM_DEPTH = tce_pkg::RAM_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tce_pkg::in_t  cmd,
    output logic          empty,
    input  logic          pop,
    output tce_pkg::out_t rsp
);

    import tce_pkg::*;

    dec_t dec_in, dec_head;
    out_t rsp_exec;
    logic dec_empty, dec_pop, rsp_push, rsp_full;

    tce_front u_front (
        .cmd (cmd),
        .dec (dec_in)
    );

    tce_queue #(
        .T     (dec_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_dec_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (dec_in),
        .full  (full),
        .pop   (dec_pop),
        .rdata (dec_head),
        .empty (dec_empty)
    );

    tce_exec #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec       (dec_head),
        .dec_empty (dec_empty),
        .dec_pop   (dec_pop),
        .rsp       (rsp_exec),
        .rsp_push  (rsp_push),
        .rsp_full  (rsp_full)
    );

    tce_queue #(
        .T     (out_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_rsp_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .wdata (rsp_exec),
        .full  (rsp_full),
        .pop   (pop),
        .rdata (rsp),
        .empty (empty)
    );

endmodule
